// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg - text console writer package
// Shared constants, microcode fields and the control program.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam logic [15:0] BLANK_CELL   = 16'h0020;
   localparam logic [7:0]  NEWLINE_CODE = 8'd10;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_PUT,
      ACT_NEWLINE,
      ACT_SCROLL_INIT,
      ACT_COPY_RD,
      ACT_COPY_WR,
      ACT_BOTTOM_INIT,
      ACT_BLANK,
      ACT_RESPOND,
      ACT_CLEAR_INIT
   } act_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_GOTO,
      BR_WAIT_REQ,
      BR_IF_WRAP,
      BR_LOOP,
      BR_WAIT_RSP
   } br_type;

   typedef logic [3:0] step_type;

   localparam step_type ST_IDLE        = 4'd0;
   localparam step_type ST_PUT         = 4'd1;
   localparam step_type ST_NEWLINE     = 4'd2;
   localparam step_type ST_SCROLL      = 4'd3;
   localparam step_type ST_COPY_RD     = 4'd4;
   localparam step_type ST_COPY_WR     = 4'd5;
   localparam step_type ST_BOTTOM      = 4'd6;
   localparam step_type ST_BLANK       = 4'd7;
   localparam step_type ST_RESPOND     = 4'd8;
   localparam step_type ST_CLEAR       = 4'd9;

   typedef struct packed {
      act_type  act;
      br_type   br;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic req_fire;
      logic req_clear;
      logic req_newline;
      logic wrap;
      logic idx_last;
      logic rsp_busy;
      logic boot;
   } seq_status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      case (step)
         ST_IDLE:    cw = '{act: ACT_NONE,        br: BR_WAIT_REQ, target: ST_IDLE};
         ST_PUT:     cw = '{act: ACT_PUT,         br: BR_IF_WRAP,  target: ST_RESPOND};
         ST_NEWLINE: cw = '{act: ACT_NEWLINE,     br: BR_IF_WRAP,  target: ST_RESPOND};
         ST_SCROLL:  cw = '{act: ACT_SCROLL_INIT, br: BR_NEXT,     target: ST_IDLE};
         ST_COPY_RD: cw = '{act: ACT_COPY_RD,     br: BR_NEXT,     target: ST_IDLE};
         ST_COPY_WR: cw = '{act: ACT_COPY_WR,     br: BR_LOOP,     target: ST_COPY_RD};
         ST_BOTTOM:  cw = '{act: ACT_BOTTOM_INIT, br: BR_NEXT,     target: ST_IDLE};
         ST_BLANK:   cw = '{act: ACT_BLANK,       br: BR_LOOP,     target: ST_BLANK};
         ST_RESPOND: cw = '{act: ACT_RESPOND,     br: BR_WAIT_RSP, target: ST_IDLE};
         ST_CLEAR:   cw = '{act: ACT_CLEAR_INIT,  br: BR_GOTO,     target: ST_BLANK};
         default:    cw = '{act: ACT_NONE,        br: BR_GOTO,     target: ST_IDLE};
      endcase
      return cw;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/tcw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_if - request and response channels
// Valid/ready channels for console requests and cursor responses.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_code;
   logic [7:0] attribute;

   modport source (output valid, output func, output char_code, output attribute,
                   input ready);
   modport sink   (input valid, input func, input char_code, input attribute,
                   output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_pos;
   logic        scrolled;

   modport source (output valid, output cursor_pos, output scrolled, input ready);
   modport sink   (input valid, input cursor_pos, input scrolled, output ready);
endinterface
`default_nettype wire

// ===== hdl/tcw_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq - microcode sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module tcw_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tcw_pkg::seq_status_type status,
   output tcw_pkg::ucode_type           cw
);

   tcw_pkg::step_type step_ff;
   tcw_pkg::step_type step_in;

   assign cw = tcw_pkg::ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      case (cw.br)
         tcw_pkg::BR_NEXT: step_in = tcw_pkg::step_type'(step_ff + 4'd1);
         tcw_pkg::BR_GOTO: step_in = cw.target;
         tcw_pkg::BR_WAIT_REQ: begin
            if (status.req_fire) begin
               if (status.req_clear)
                  step_in = tcw_pkg::ST_CLEAR;
               else if (status.req_newline)
                  step_in = tcw_pkg::ST_NEWLINE;
               else
                  step_in = tcw_pkg::ST_PUT;
            end
         end
         tcw_pkg::BR_IF_WRAP: step_in = status.wrap ? tcw_pkg::ST_SCROLL : cw.target;
         tcw_pkg::BR_LOOP: begin
            step_in = status.idx_last ? tcw_pkg::step_type'(step_ff + 4'd1) : cw.target;
         end
         tcw_pkg::BR_WAIT_RSP: begin
            if (status.boot || !status.rsp_busy)
               step_in = cw.target;
         end
         default: step_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // reset starts at the clear routine so the screen store is blanked
   always_ff @(posedge clock) begin
      if (reset)
         step_ff <= tcw_pkg::ST_CLEAR;
      else
         step_ff <= step_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= tcw_pkg::ST_CLEAR)
      else $error("sequencer step out of program");

   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      (cw.br == tcw_pkg::BR_WAIT_REQ && status.req_fire) |=> step_ff != tcw_pkg::ST_IDLE)
      else $error("accepted request not dispatched");

   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      (step_ff == tcw_pkg::ST_BLANK && status.idx_last) |=> step_ff == tcw_pkg::ST_RESPOND)
      else $error("blank loop did not exit to respond");

endmodule
`default_nettype wire

// ===== hdl/text_console_char_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer - text console character writer
// Screen store with cursor; put, newline, scroll and clear run as microcode.
// ----------------------------------------------------------------------------
// channel   dir  fields                            accepted when
// req_chan  in   func, char_code, attribute        valid && ready
// rsp_chan  out  cursor_pos, scrolled              valid && ready
//
// Put or newline without scroll: accept, update and respond steps.
// Scroll adds a copy loop of one read and one write per cell over the single
// memory port pair, then blanks the bottom row.
// Clear blanks every cell, then responds. After reset a blanking pass runs
// before the first request is taken.
// Response register holds a result; the next response step stalls until taken.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(CELLS);
   localparam int COLW  = $clog2(COLUMNS);
   localparam int ROWW  = $clog2(ROWS);

   localparam logic [CW-1:0]   CELLS_LAST   = CW'(CELLS - 1);
   localparam logic [CW-1:0]   COPY_LAST    = CW'(CELLS - COLUMNS - 1);
   localparam logic [CW-1:0]   BOTTOM_START = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   ROW_STEP     = CW'(COLUMNS);
   localparam logic [COLW-1:0] COL_LAST     = COLW'(COLUMNS - 1);
   localparam logic [ROWW-1:0] ROW_LAST     = ROWW'(ROWS - 1);

   tcw_pkg::ucode_type      cw;
   tcw_pkg::seq_status_type status;

   logic [15:0]     mem [CELLS];
   logic [15:0]     rd_data_ff;
   logic            mem_rd_en;
   logic [CW-1:0]   mem_rd_addr;
   logic            mem_wr_en;
   logic [CW-1:0]   mem_wr_addr;
   logic [15:0]     mem_wr_data;

   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [ROWW-1:0] row_ff, row_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            scrolled_ff, scrolled_in;
   logic            boot_ff, boot_in;
   logic [7:0]      char_ff, char_in;
   logic [7:0]      attr_ff, attr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [10:0]     rsp_cursor_ff, rsp_cursor_in;
   logic            rsp_scrolled_ff, rsp_scrolled_in;

   logic req_fire;
   logic rsp_busy;

   tcw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   assign req_chan.ready      = (cw.br == tcw_pkg::BR_WAIT_REQ);
   assign req_fire            = req_chan.valid && req_chan.ready;
   assign rsp_busy            = rsp_valid_ff && !rsp_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_pos = rsp_cursor_ff;
   assign rsp_chan.scrolled   = rsp_scrolled_ff;

   always_comb begin
      status.req_fire    = req_fire;
      status.req_clear   = req_chan.func;
      status.req_newline = (req_chan.char_code == tcw_pkg::NEWLINE_CODE);
      status.wrap        = (row_ff == ROW_LAST) &&
                           ((cw.act != tcw_pkg::ACT_PUT) || (col_ff == COL_LAST));
      status.idx_last    = (cw.act == tcw_pkg::ACT_COPY_WR) ? (idx_ff == COPY_LAST)
                                                            : (idx_ff == CELLS_LAST);
      status.rsp_busy    = rsp_busy;
      status.boot        = boot_ff;
   end

   always_comb begin
      cursor_in       = cursor_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      idx_in          = idx_ff;
      scrolled_in     = scrolled_ff;
      boot_in         = boot_ff;
      char_in         = char_ff;
      attr_in         = attr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = CW'(idx_ff + ROW_STEP);
      mem_wr_en       = 1'b0;
      mem_wr_addr     = idx_ff;
      mem_wr_data     = tcw_pkg::BLANK_CELL;

      case (cw.act)
         tcw_pkg::ACT_NONE: begin
            if (req_fire) begin
               char_in     = req_chan.char_code;
               attr_in     = req_chan.attribute;
               scrolled_in = 1'b0;
            end
         end
         tcw_pkg::ACT_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cursor_ff;
            mem_wr_data = {attr_ff, char_ff};
            if (col_ff == COL_LAST) begin
               if (row_ff != ROW_LAST) begin
                  col_in    = '0;
                  row_in    = row_ff + 1'b1;
                  cursor_in = cursor_ff + 1'b1;
               end
            end else begin
               col_in    = col_ff + 1'b1;
               cursor_in = cursor_ff + 1'b1;
            end
         end
         tcw_pkg::ACT_NEWLINE: begin
            if (row_ff != ROW_LAST) begin
               col_in    = '0;
               row_in    = row_ff + 1'b1;
               cursor_in = CW'(cursor_ff - CW'(col_ff) + ROW_STEP);
            end
         end
         tcw_pkg::ACT_SCROLL_INIT: begin
            idx_in      = '0;
            scrolled_in = 1'b1;
         end
         tcw_pkg::ACT_COPY_RD: begin
            mem_rd_en = 1'b1;
         end
         tcw_pkg::ACT_COPY_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = rd_data_ff;
            idx_in      = idx_ff + 1'b1;
         end
         tcw_pkg::ACT_BOTTOM_INIT: begin
            idx_in    = BOTTOM_START;
            cursor_in = BOTTOM_START;
            row_in    = ROW_LAST;
            col_in    = '0;
         end
         tcw_pkg::ACT_BLANK: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         tcw_pkg::ACT_RESPOND: begin
            if (boot_ff) begin
               boot_in = 1'b0;
            end else if (!rsp_busy) begin
               rsp_valid_in    = 1'b1;
               rsp_cursor_in   = 11'(cursor_ff);
               rsp_scrolled_in = scrolled_ff;
            end
         end
         tcw_pkg::ACT_CLEAR_INIT: begin
            idx_in      = '0;
            cursor_in   = '0;
            col_in      = '0;
            row_in      = '0;
            scrolled_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en)
         mem[mem_wr_addr] <= mem_wr_data;
      if (mem_rd_en)
         rd_data_ff <= mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         scrolled_ff  <= 1'b0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scrolled_ff  <= scrolled_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      char_ff         <= char_in;
      attr_ff         <= attr_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CELLS_LAST)
      else $error("cursor beyond last cell");

   a_cursor_rowcol: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) == 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff))
      else $error("cursor out of step with row and column");

   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_chan.ready) ##1 rsp_valid_ff
      |-> $past(cw.act == tcw_pkg::ACT_RESPOND) && !$past(boot_ff))
      else $error("response raised outside respond step");

   a_put_writes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.func && req_chan.char_code != tcw_pkg::NEWLINE_CODE)
      |=> mem_wr_en && mem_wr_addr == cursor_ff)
      else $error("put request did not write at cursor");

endmodule
`default_nettype wire

// ===== test/tcw_cursor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor_checker - cursor and scroll checker for the console writer
// Watches both channels, tracks the cursor for every accepted request and
// compares each response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcw_cursor_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic clock,
   input  logic reset,
   tcw_req_if   req_chan,
   tcw_rsp_if   rsp_chan,
   output int   failures,
   output int   outstanding
);

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic        scrolled;
   } cursor_report_type;

   cursor_report_type expected_reports[$];
   cursor_report_type oldest;
   // cell contents never reach the response port, so only the cursor is kept
   int                cursor;

   function automatic cursor_report_type step_cursor(input logic func,
                                                     input logic [7:0] char_code);
      cursor_report_type report;
      int                next_row;
      report.scrolled = 1'b0;
      if (func) begin
         cursor = 0;
      end else if (char_code == tcw_pkg::NEWLINE_CODE) begin
         next_row = (cursor / COLUMNS + 1) * COLUMNS;
         if (next_row >= CELLS) begin
            cursor          = CELLS - COLUMNS;
            report.scrolled = 1'b1;
         end else begin
            cursor = next_row;
         end
      end else begin
         cursor++;
         if (cursor >= CELLS) begin
            cursor          = CELLS - COLUMNS;
            report.scrolled = 1'b1;
         end
      end
      report.cursor_pos = cursor[10:0];
      return report;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cursor = 0;
         expected_reports.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_reports.push_back(step_cursor(req_chan.func, req_chan.char_code));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               $error("response with no request outstanding: cursor_pos %0d scrolled %0b",
                      rsp_chan.cursor_pos, rsp_chan.scrolled);
               failures++;
            end else begin
               oldest = expected_reports.pop_front();
               if (rsp_chan.cursor_pos !== oldest.cursor_pos) begin
                  $error("cursor_pos: expected %0d, actual %0d",
                         oldest.cursor_pos, rsp_chan.cursor_pos);
                  failures++;
               end
               if (rsp_chan.scrolled !== oldest.scrolled) begin
                  $error("scrolled: expected %0b, actual %0b",
                         oldest.scrolled, rsp_chan.scrolled);
                  failures++;
               end
            end
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - console character writer testbench
// Drives directed and random put, newline and clear requests with varying
// request gaps and response back-pressure; the checker judges every response.
// ----------------------------------------------------------------------------
module tb;

   localparam int COLUMNS      = tcw_pkg::COLUMNS_DEF;
   localparam int ROWS         = tcw_pkg::ROWS_DEF;
   localparam int PHASE_ITEMS  = 380;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   outstanding;
   int   send_idle_pct;
   int   recv_idle_pct;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   text_console_char_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tcw_cursor_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // starts and ends on a falling edge
   task automatic send_request(input logic func, input logic [7:0] char_code,
                               input logic [7:0] attribute);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.func      = func;
      req_chan.char_code = char_code;
      req_chan.attribute = attribute;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_random_requests(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(999);
         if (pick < 3)
            send_request(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
         else if (pick < 153)
            send_request(1'b0, tcw_pkg::NEWLINE_CODE, 8'($urandom_range(255)));
         else
            send_request(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.func      = 1'b0;
      req_chan.char_code = 8'h00;
      req_chan.attribute = 8'h00;
      send_idle_pct      = 22;
      recv_idle_pct      = 61;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      send_request(1'b0, 8'h00, 8'h00);
      send_request(1'b0, 8'hFF, 8'hFF);
      send_request(1'b0, 8'h55, 8'hAA);
      send_request(1'b0, tcw_pkg::NEWLINE_CODE, 8'hFF);
      send_request(1'b0, 8'hAA, 8'h55);
      send_request(1'b0, tcw_pkg::NEWLINE_CODE, 8'h00);
      send_request(1'b1, 8'hFF, 8'hFF);
      send_request(1'b0, 8'h20, 8'h00);
      send_request(1'b1, tcw_pkg::NEWLINE_CODE, 8'h00);
      send_request(1'b0, 8'h7F, 8'h80);

      send_random_requests(PHASE_ITEMS);
      send_idle_pct = 61;
      recv_idle_pct = 22;
      send_random_requests(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_requests(PHASE_ITEMS);
      req_chan.valid = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0)
         $display("[text_console_char_writer] OK");
      else
         $display("[text_console_char_writer] ERROR");
      $finish;
   end

   initial begin
      #(64'd250_000_000);
      $display("[text_console_char_writer] ERROR");
      $finish;
   end

endmodule
